@@ design/stereo_minmax_waveform_columns_unit_macros.svh @@
// Assertion shorthands used by the checker of this block.
`ifndef STEREO_MINMAX_WAVEFORM_COLUMNS_UNIT_MACROS_SVH
`define STEREO_MINMAX_WAVEFORM_COLUMNS_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SMWC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smwc assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define SMWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smwc assertion failed");

`endif

@@ design/smwc_pkg.sv @@
package smwc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ROW_W      = 7;
  localparam int COL_W      = 8;
  localparam int FPP_W      = 24;
  localparam int PPC_W      = 16;
  localparam int SKIP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_PEAK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAKS_PER_COLUMN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_PEAKS       = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  // full-scale magnitude used for the vertical scale
  localparam int FULL_SCALE = 32'h8000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } frame_t;

  typedef struct packed {
    logic [COL_W-1:0] column_index;
    logic [ROW_W-1:0] left_top_row;
    logic [ROW_W-1:0] left_bottom_row;
    logic [ROW_W-1:0] right_top_row;
    logic [ROW_W-1:0] right_bottom_row;
  } column_t;

  typedef struct packed {
    logic [FPP_W-1:0]  frames_per_peak;
    logic [PPC_W-1:0]  peaks_per_column;
    logic [SKIP_W-1:0] skip_peaks;
  } cfg_t;

  // finished column, still in sample units
  typedef struct packed {
    logic [COL_W-1:0]           column_index;
    logic signed [SAMPLE_W-1:0] left_max;
    logic signed [SAMPLE_W-1:0] left_min;
    logic signed [SAMPLE_W-1:0] right_max;
    logic signed [SAMPLE_W-1:0] right_min;
  } span_t;

endpackage

@@ design/smwc_fold.sv @@
module smwc_fold #(
  parameter int DISPLAY_WIDTH = 160
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  smwc_pkg::frame_t     frame,
  input  smwc_pkg::cfg_t       cfg,
  output logic                 emit,
  output smwc_pkg::span_t      span
);
  import smwc_pkg::*;

  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(DISPLAY_WIDTH);

  logic signed [SAMPLE_W-1:0] pk_lmin, pk_lmax, pk_rmin, pk_rmax;
  logic signed [SAMPLE_W-1:0] pk_lmin_next, pk_lmax_next, pk_rmin_next, pk_rmax_next;
  logic [FPP_W-1:0]           frames_left, frames_left_next;
  logic                       group_fresh, group_fresh_next;
  logic [SKIP_W-1:0]          peaks_skipped, peaks_skipped_next;
  logic [FPP_W-1:0]           peaks_in_view, peaks_in_view_next;
  logic signed [SAMPLE_W-1:0] col_lmin, col_lmax, col_rmin, col_rmax;
  logic signed [SAMPLE_W-1:0] col_lmin_next, col_lmax_next, col_rmin_next, col_rmax_next;
  logic signed [SAMPLE_W-1:0] fold_lmin, fold_lmax, fold_rmin, fold_rmax;
  logic [COL_W-1:0]           next_column, next_column_next;
  logic [FPP_W-1:0]           fpp_eff, count, piv_inc;
  logic [PPC_W-1:0]           need;
  logic signed [SAMPLE_W-1:0] l, r;

  assign l = frame.left_sample;
  assign r = frame.right_sample;

  assign fpp_eff = (cfg.frames_per_peak == '0) ? FPP_W'(1) : cfg.frames_per_peak;
  // a fresh group loads its frame count from the register at its first frame
  assign count   = group_fresh ? fpp_eff : frames_left;

  assign pk_lmin_next = (group_fresh || l < pk_lmin) ? l : pk_lmin;
  assign pk_lmax_next = (group_fresh || l > pk_lmax) ? l : pk_lmax;
  assign pk_rmin_next = (group_fresh || r < pk_rmin) ? r : pk_rmin;
  assign pk_rmax_next = (group_fresh || r > pk_rmax) ? r : pk_rmax;

  assign fold_lmin = (pk_lmin_next < col_lmin) ? pk_lmin_next : col_lmin;
  assign fold_lmax = (pk_lmax_next > col_lmax) ? pk_lmax_next : col_lmax;
  assign fold_rmin = (pk_rmin_next < col_rmin) ? pk_rmin_next : col_rmin;
  assign fold_rmax = (pk_rmax_next > col_rmax) ? pk_rmax_next : col_rmax;

  assign piv_inc = peaks_in_view + FPP_W'(1);
  // column 0 closes after a single peak
  assign need = (next_column == '0 || cfg.peaks_per_column == '0) ? PPC_W'(1)
              : cfg.peaks_per_column;

  always_comb begin
    frames_left_next   = frames_left;
    group_fresh_next   = group_fresh;
    peaks_skipped_next = peaks_skipped;
    peaks_in_view_next = peaks_in_view;
    col_lmin_next      = col_lmin;
    col_lmax_next      = col_lmax;
    col_rmin_next      = col_rmin;
    col_rmax_next      = col_rmax;
    next_column_next   = next_column;
    emit               = 1'b0;
    if (count > FPP_W'(1)) begin
      frames_left_next = count - FPP_W'(1);
      group_fresh_next = 1'b0;
    end else begin
      frames_left_next = '0;
      group_fresh_next = 1'b1;
      if (peaks_skipped < cfg.skip_peaks) begin
        peaks_skipped_next = peaks_skipped + SKIP_W'(1);
      end else if (next_column < COL_LIMIT) begin
        if (piv_inc < FPP_W'(need)) begin
          col_lmin_next      = fold_lmin;
          col_lmax_next      = fold_lmax;
          col_rmin_next      = fold_rmin;
          col_rmax_next      = fold_rmax;
          peaks_in_view_next = piv_inc;
        end else begin
          emit               = 1'b1;
          next_column_next   = next_column + COL_W'(1);
          col_lmin_next      = SAMPLE_MAX;
          col_lmax_next      = SAMPLE_MIN;
          col_rmin_next      = SAMPLE_MAX;
          col_rmax_next      = SAMPLE_MIN;
          peaks_in_view_next = '0;
        end
      end
    end
  end

  assign span.column_index = next_column;
  assign span.left_max     = fold_lmax;
  assign span.left_min     = fold_lmin;
  assign span.right_max    = fold_rmax;
  assign span.right_min    = fold_rmin;

  always_ff @(posedge clk) begin
    if (rst) begin
      pk_lmin       <= '0;
      pk_lmax       <= '0;
      pk_rmin       <= '0;
      pk_rmax       <= '0;
      frames_left   <= '0;
      group_fresh   <= 1'b1;
      peaks_skipped <= '0;
      peaks_in_view <= '0;
      col_lmin      <= SAMPLE_MAX;
      col_lmax      <= SAMPLE_MIN;
      col_rmin      <= SAMPLE_MAX;
      col_rmax      <= SAMPLE_MIN;
      next_column   <= '0;
    end else if (step) begin
      pk_lmin       <= pk_lmin_next;
      pk_lmax       <= pk_lmax_next;
      pk_rmin       <= pk_rmin_next;
      pk_rmax       <= pk_rmax_next;
      frames_left   <= frames_left_next;
      group_fresh   <= group_fresh_next;
      peaks_skipped <= peaks_skipped_next;
      peaks_in_view <= peaks_in_view_next;
      col_lmin      <= col_lmin_next;
      col_lmax      <= col_lmax_next;
      col_rmin      <= col_rmin_next;
      col_rmax      <= col_rmax_next;
      next_column   <= next_column_next;
    end
  end

endmodule

@@ design/smwc_row.sv @@
module smwc_row #(
  parameter int DISPLAY_HEIGHT = 128,
  parameter int ZERO_ROW       = 32
) (
  input  logic signed [smwc_pkg::SAMPLE_W-1:0] value,
  output logic [smwc_pkg::ROW_W-1:0]           row
);
  import smwc_pkg::*;

  localparam int QUARTER = DISPLAY_HEIGHT / 4;
  localparam int YSCALE  = FULL_SCALE / QUARTER + 1;
  // round-up reciprocal, exact for any 16-bit magnitude
  localparam int SHIFT   = SAMPLE_W + $clog2(YSCALE);
  localparam longint MULT = ((64'sd1 <<< SHIFT) + YSCALE - 1) / YSCALE;
  localparam int MULT_W  = SAMPLE_W + 2;
  localparam int PROD_W  = SAMPLE_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT_C = MULT_W'(MULT);
  localparam logic [ROW_W-1:0]  ZERO_C = ROW_W'(ZERO_ROW);

  logic              neg;
  logic [SAMPLE_W-1:0] mag;
  logic [PROD_W-1:0] prod, quot;
  logic [ROW_W-1:0]  q7;

  assign neg  = value[SAMPLE_W-1];
  assign mag  = neg ? (~value + SAMPLE_W'(1)) : value;
  assign prod = PROD_W'(mag) * PROD_W'(MULT_C);
  assign quot = prod >> SHIFT;
  assign q7   = quot[ROW_W-1:0];
  // truncation toward zero: the quotient takes the sign of the value
  assign row  = neg ? (ZERO_C + q7) : (ZERO_C - q7);

endmodule

@@ design/stereo_minmax_waveform_columns_unit.sv @@
// Min/max waveform columns for a stereo 16-bit PCM stream. One frame goes in per
// word on in_word; frames fold into peaks of frames_per_peak frames, the first
// skip_peaks peaks are dropped, and peaks then fold into display columns (column 0
// holds one peak, later ones peaks_per_column, zero meaning one). Each finished
// column comes out as one word with its index and the left/right top and bottom
// pixel rows; after DISPLAY_WIDTH columns nothing more is sent until reset. The
// block takes one frame per cycle unless stalled; every stage is a register step:
// frame register, span register and output word register. A stall against a
// waiting column word holds the whole pipeline and shows at once on in_stall.
// Registers are written through the cfg port, which is always ready; write them
// only when the block is idle. Incomplete trailing groups never produce a word.
module stereo_minmax_waveform_columns_unit #(
  parameter int DISPLAY_WIDTH  = 160,
  parameter int DISPLAY_HEIGHT = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  smwc_pkg::frame_t                    in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output smwc_pkg::column_t                   out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smwc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import smwc_pkg::*;

  localparam int QUARTER = DISPLAY_HEIGHT / 4;

  cfg_t    cfg;
  logic    advance;
  logic    s1_valid;
  frame_t  s1_word;
  logic    emit;
  span_t   span;
  logic    s2_valid;
  span_t   s2_span;
  column_t rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frames_per_peak  <= FPP_W'(1);
      cfg.peaks_per_column <= PPC_W'(1);
      cfg.skip_peaks       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAMES_PER_PEAK:  cfg.frames_per_peak  <= cfg_data[FPP_W-1:0];
        REG_PEAKS_PER_COLUMN: cfg.peaks_per_column <= cfg_data[PPC_W-1:0];
        REG_SKIP_PEAKS:       cfg.skip_peaks       <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // the pipeline moves unless a finished word is held by the sink
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_word <= in_word;
    end
  end

  smwc_fold #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH)
  ) u_fold (
    .clk   (clk),
    .rst   (rst),
    .step  (advance && s1_valid),
    .frame (s1_word),
    .cfg   (cfg),
    .emit  (emit),
    .span  (span)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_span <= span;
    end
  end

  assign rows.column_index = s2_span.column_index;

  smwc_row #(.DISPLAY_HEIGHT(DISPLAY_HEIGHT), .ZERO_ROW(QUARTER)) u_row_lt (
    .value (s2_span.left_max),
    .row   (rows.left_top_row)
  );

  smwc_row #(.DISPLAY_HEIGHT(DISPLAY_HEIGHT), .ZERO_ROW(QUARTER)) u_row_lb (
    .value (s2_span.left_min),
    .row   (rows.left_bottom_row)
  );

  smwc_row #(.DISPLAY_HEIGHT(DISPLAY_HEIGHT), .ZERO_ROW(3 * QUARTER)) u_row_rt (
    .value (s2_span.right_max),
    .row   (rows.right_top_row)
  );

  smwc_row #(.DISPLAY_HEIGHT(DISPLAY_HEIGHT), .ZERO_ROW(3 * QUARTER)) u_row_rb (
    .value (s2_span.right_min),
    .row   (rows.right_bottom_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= rows;
    end
  end

endmodule

@@ design/smwc_checker.sv @@
`include "stereo_minmax_waveform_columns_unit_macros.svh"

module smwc_checker #(
  parameter int DISPLAY_WIDTH = 160
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input smwc_pkg::column_t               out_word,
  input logic                            cfg_ready
);
  import smwc_pkg::*;

  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(DISPLAY_WIDTH);

  // a held result word stays put
  `SMWC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // backpressure on input only comes from a blocked output word
  `SMWC_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall)

  // no column past the display edge
  `SMWC_ASSERT_NOW(a_col_range, out_valid, out_word.column_index < COL_LIMIT)

  // register writes are never held off
  `SMWC_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind stereo_minmax_waveform_columns_unit smwc_checker #(
  .DISPLAY_WIDTH(DISPLAY_WIDTH)
) u_smwc_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import smwc_pkg::*;

  localparam int DISPLAY_WIDTH  = 160;
  localparam int DISPLAY_HEIGHT = 128;
  localparam int LEFT_ZERO      = DISPLAY_HEIGHT / 4;
  localparam int RIGHT_ZERO     = 3 * (DISPLAY_HEIGHT / 4);
  localparam int Y_SCALE        = FULL_SCALE / (DISPLAY_HEIGHT / 4) + 1;
  localparam int DRAIN_CYCLES   = 8;       // pipeline is three deep
  localparam int CYCLE_LIMIT    = 300000;
  localparam int SEGMENT_FRAMES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  frame_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  column_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int tx_idle_pct = 15;
  int rx_idle_pct = 66;
  logic rx_quiet = 1'b0;

  int errors = 0;
  int cycle_count = 0;
  int frames_taken = 0;
  int columns_seen = 0;
  int cfg_writes = 0;

  // column predictor state
  logic [FPP_W-1:0]           grp_span;
  logic [PPC_W-1:0]           col_span;
  logic [SKIP_W-1:0]          skip_target;
  logic signed [SAMPLE_W-1:0] grp_lo_l, grp_hi_l, grp_lo_r, grp_hi_r;
  logic [FPP_W-1:0]           grp_remaining;
  logic                       grp_open;
  logic [SKIP_W-1:0]          drop_count;
  logic [23:0]                span_peaks;
  logic signed [SAMPLE_W-1:0] acc_lo_l, acc_hi_l, acc_lo_r, acc_hi_r;
  int unsigned                col_ptr;
  column_t                    pending_cols[$];

  stereo_minmax_waveform_columns_unit #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rx_quiet && ($urandom_range(99) < rx_idle_pct);
  end

  function automatic logic [ROW_W-1:0] row_of(input int zero,
                                               input logic signed [SAMPLE_W-1:0] v);
    int r;
    r = zero - int'(v) / Y_SCALE;
    return r[ROW_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic clear_span();
    acc_lo_l = SAMPLE_MAX;
    acc_hi_l = SAMPLE_MIN;
    acc_lo_r = SAMPLE_MAX;
    acc_hi_r = SAMPLE_MIN;
    span_peaks = '0;
  endtask

  task automatic fold_frame(input frame_t f);
    logic signed [SAMPLE_W-1:0] l, r;
    int unsigned wanted;
    column_t c;
    l = f.left_sample;
    r = f.right_sample;
    if (!grp_open) begin
      grp_lo_l = l;
      grp_hi_l = l;
      grp_lo_r = r;
      grp_hi_r = r;
      grp_remaining = (grp_span == '0) ? FPP_W'(1) : grp_span;
      grp_open = 1'b1;
    end
    if (l < grp_lo_l) grp_lo_l = l;
    if (l > grp_hi_l) grp_hi_l = l;
    if (r < grp_lo_r) grp_lo_r = r;
    if (r > grp_hi_r) grp_hi_r = r;
    if (grp_remaining > 1) begin
      grp_remaining--;
      return;
    end
    grp_remaining = '0;
    grp_open = 1'b0;
    // peak complete
    if (drop_count < skip_target) begin
      drop_count++;
      return;
    end
    if (col_ptr >= DISPLAY_WIDTH) return;
    if (grp_lo_l < acc_lo_l) acc_lo_l = grp_lo_l;
    if (grp_hi_l > acc_hi_l) acc_hi_l = grp_hi_l;
    if (grp_lo_r < acc_lo_r) acc_lo_r = grp_lo_r;
    if (grp_hi_r > acc_hi_r) acc_hi_r = grp_hi_r;
    span_peaks = span_peaks + 24'd1;
    wanted = (col_ptr == 0 || col_span == '0) ? 1 : 32'(col_span);
    if (span_peaks < wanted) return;
    c.column_index     = col_ptr[COL_W-1:0];
    c.left_top_row     = row_of(LEFT_ZERO, acc_hi_l);
    c.left_bottom_row  = row_of(LEFT_ZERO, acc_lo_l);
    c.right_top_row    = row_of(RIGHT_ZERO, acc_hi_r);
    c.right_bottom_row = row_of(RIGHT_ZERO, acc_lo_r);
    pending_cols.push_back(c);
    col_ptr++;
    clear_span();
  endtask

  // predictor follows every accepted word and register write
  always @(posedge clk) begin
    if (rst) begin
      grp_span = FPP_W'(1);
      col_span = PPC_W'(1);
      skip_target = '0;
      grp_lo_l = '0;
      grp_hi_l = '0;
      grp_lo_r = '0;
      grp_hi_r = '0;
      grp_remaining = '0;
      grp_open = 1'b0;
      drop_count = '0;
      col_ptr = 0;
      clear_span();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          REG_FRAMES_PER_PEAK:  grp_span = cfg_data[FPP_W-1:0];
          REG_PEAKS_PER_COLUMN: col_span = cfg_data[PPC_W-1:0];
          REG_SKIP_PEAKS:       skip_target = cfg_data[SKIP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        frames_taken++;
        fold_frame(in_word);
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    column_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      columns_seen++;
      if (pending_cols.size() == 0) begin
        errors++;
        $display("%0t: unexpected column word, expected none, got %h", $time, out_word);
      end else begin
        exp_c = pending_cols.pop_front();
        check_field("column_index", exp_c.column_index, out_word.column_index);
        check_field("left_top_row", exp_c.left_top_row, out_word.left_top_row);
        check_field("left_bottom_row", exp_c.left_bottom_row, out_word.left_bottom_row);
        check_field("right_top_row", exp_c.right_top_row, out_word.right_top_row);
        check_field("right_bottom_row", exp_c.right_bottom_row,
                    out_word.right_bottom_row);
      end
    end
  end

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
    frame_t f;
    f.left_sample = l;
    f.right_sample = r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= f;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_frame(rand_sample(), rand_sample());
  endtask

  // sender holds off until every predicted column is back and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cols.size() != 0) @(posedge clk);
    rx_quiet <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    rx_quiet <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [FPP_W-1:0] fpp, input logic [PPC_W-1:0] ppc,
                            input logic [SKIP_W-1:0] skip);
    write_reg(REG_FRAMES_PER_PEAK, fpp);
    write_reg(REG_PEAKS_PER_COLUMN, CFG_DATA_W'(ppc));
    write_reg(REG_SKIP_PEAKS, skip);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_regs();
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(16'sd0, -16'sd1);
    send_frame(16'sd1, -16'sd32767);
    wait_idle();
  endtask

  // zero in either size register behaves as one
  task automatic test_zero_sizes();
    set_config('0, '0, '0);
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    send_frame(-16'sd1025, 16'sd1024);
    wait_idle();
  endtask

  // running group keeps the length it started with
  task automatic test_group_resize();
    set_config(24'd3, 16'd2, '0);
    send_frame(16'sd5000, -16'sd5000);
    wait_idle();
    set_config(24'd1, 16'd2, '0);
    send_frame(-16'sd20000, 16'sd100);
    send_frame(16'sd300, 16'sd31000);
    send_frame(16'sd0, 16'sd0);
    wait_idle();
  endtask

  // open column closes on its next peak once the target drops below its count
  task automatic test_column_shrink();
    set_config(24'd1, 16'hFFFF, '0);
    send_random(4);
    wait_idle();
    set_config(24'd1, 16'd2, '0);
    send_random(1);
    wait_idle();
  endtask

  task automatic test_skip_raise();
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    wait_idle();
    set_config(24'd1, 16'd2, drop_count + SKIP_W'(2));
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(16'sd0, 16'sd0);
    wait_idle();
    set_config(24'd1, 16'd2, 24'hFFFFFF);
    send_random(2);
    wait_idle();
  endtask

  // sizes chosen per segment so columns keep coming until col_goal
  task automatic test_random_stream(input int tx_pct, input int rx_pct, input int frames,
                                    input int col_goal);
    int segs, cols_left, per_seg, fpc, fpp, ppc;
    segs = frames / SEGMENT_FRAMES;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    for (int s = 0; s < segs; s++) begin
      cols_left = col_goal - int'(col_ptr);
      if (cols_left < 1) cols_left = 1;
      per_seg = cols_left / (segs - s);
      if (per_seg < 1) per_seg = 1;
      fpc = SEGMENT_FRAMES / per_seg;
      if (fpc < 1) fpc = 1;
      fpp = $urandom_range(1, (fpc > 8) ? 8 : fpc);
      ppc = fpc / fpp;
      if (ppc < 1) ppc = 1;
      if (fpp == 1 && $urandom_range(1)) fpp = 0;
      if (ppc == 1 && $urandom_range(1)) ppc = 0;
      set_config(FPP_W'(fpp), PPC_W'(ppc), SKIP_W'(drop_count + $urandom_range(2)));
      send_random(SEGMENT_FRAMES);
      wait_idle();
    end
  endtask

  task automatic test_display_full();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    set_config(24'd1, 16'd1, '0);
    send_random(DISPLAY_WIDTH - int'(col_ptr) + 8);
    wait_idle();
    set_config(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
    send_random(4);
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_regs();
    test_zero_sizes();
    test_group_resize();
    test_column_shrink();
    test_skip_raise();
    test_random_stream(15, 66, 600, 50);
    test_random_stream(66, 15, 600, 100);
    test_random_stream(0, 0, 600, 150);
    test_display_full();
    wait_idle();
    $display("Run covered %0d frames and %0d column words over %0d register writes,",
             frames_taken, columns_seen, cfg_writes);
    $display("with both sides stalling in turn and the display filled to %0d columns.",
             col_ptr);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
